// ===== rtl/hcw_pkg.sv =====
package hcw_pkg;

  // Input item actions
  localparam logic [1:0] ACT_ARM  = 2'd0;
  localparam logic [1:0] ACT_BYTE = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  // Result outcomes
  localparam logic [1:0] OUT_OK      = 2'd0;
  localparam logic [1:0] OUT_FAILED  = 2'd1;
  localparam logic [1:0] OUT_TIMEOUT = 2'd2;

  // H4 / HCI constants
  localparam logic [7:0] H4_EVENT_TYPE     = 8'h04;
  localparam logic [7:0] EVT_CMD_COMPLETE  = 8'h0E;
  localparam logic [7:0] STATUS_SUCCESS    = 8'h00;
  localparam logic [7:0] CMD_COMPLETE_MIN  = 8'd4;
  localparam logic [7:0] IDX_OPCODE_LO     = 8'd1;
  localparam logic [7:0] IDX_OPCODE_HI     = 8'd2;
  localparam logic [7:0] IDX_STATUS        = 8'd3;

  typedef struct packed {
    logic [1:0] action;
    logic [15:0] expected_opcode;
    logic [15:0] wait_ms;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [1:0] outcome;
    logic [7:0] status_code;
  } result_t;

endpackage

// ===== rtl/hcw_if.sv =====
interface hcw_in_if;
  logic valid;
  logic ready;
  logic [1:0] action;
  logic [15:0] expected_opcode;
  logic [15:0] wait_ms;
  logic [7:0] rx_byte;

  modport source (output valid, action, expected_opcode, wait_ms, rx_byte, input ready);
  modport sink (input valid, action, expected_opcode, wait_ms, rx_byte, output ready);
endinterface

interface hcw_out_if;
  logic valid;
  logic ready;
  logic [1:0] outcome;
  logic [7:0] status_code;

  modport source (output valid, outcome, status_code, input ready);
  modport sink (input valid, outcome, status_code, output ready);
endinterface

// ===== rtl/hcw_core.sv =====
module hcw_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  hcw_pkg::item_t  item,
  output logic            res_valid,
  output hcw_pkg::result_t res
);
  import hcw_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TYPE,
    PH_EVENT,
    PH_LEN,
    PH_PARAMS
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  event_code, event_code_next;
  logic [7:0]  param_length, param_length_next;
  logic [7:0]  param_index, param_index_next;
  logic [15:0] seen_opcode, seen_opcode_next;
  logic [7:0]  seen_status, seen_status_next;
  logic [15:0] wanted_opcode, wanted_opcode_next;
  logic [15:0] limit_ms, limit_ms_next;
  logic [15:0] elapsed_ms, elapsed_ms_next;
  logic [15:0] gap_ms, gap_ms_next;

  logic       between;
  logic       eop;
  logic       fin;
  logic [1:0] fin_outcome;
  logic [7:0] fin_status;
  logic [7:0] index_inc;

  assign index_inc = param_index + 8'd1;

  always_comb begin
    phase_next         = phase;
    event_code_next    = event_code;
    param_length_next  = param_length;
    param_index_next   = param_index;
    seen_opcode_next   = seen_opcode;
    seen_status_next   = seen_status;
    wanted_opcode_next = wanted_opcode;
    limit_ms_next      = limit_ms;
    elapsed_ms_next    = elapsed_ms;
    gap_ms_next        = gap_ms;
    between            = 1'b0;
    eop                = 1'b0;
    fin                = 1'b0;
    fin_outcome        = OUT_TIMEOUT;
    fin_status         = 8'd0;

    if (accept) begin
      case (item.action)
        ACT_ARM: begin
          wanted_opcode_next = item.expected_opcode;
          limit_ms_next      = item.wait_ms;
          elapsed_ms_next    = 16'd0;
          gap_ms_next        = 16'd0;
          between            = 1'b1;
        end
        ACT_BYTE: begin
          if (phase != PH_IDLE) begin
            gap_ms_next = 16'd0;
            unique case (phase)
              PH_TYPE: begin
                if (item.rx_byte != H4_EVENT_TYPE) between = 1'b1;
                else phase_next = PH_EVENT;
              end
              PH_EVENT: begin
                event_code_next = item.rx_byte;
                phase_next      = PH_LEN;
              end
              PH_LEN: begin
                param_length_next = item.rx_byte;
                param_index_next  = 8'd0;
                if (item.rx_byte == 8'd0) eop = 1'b1;
                else phase_next = PH_PARAMS;
              end
              PH_PARAMS: begin
                if (param_index == IDX_OPCODE_LO) seen_opcode_next[7:0] = item.rx_byte;
                else if (param_index == IDX_OPCODE_HI) seen_opcode_next[15:8] = item.rx_byte;
                else if (param_index == IDX_STATUS) seen_status_next = item.rx_byte;
                param_index_next = index_inc;
                if (index_inc >= param_length) eop = 1'b1;
              end
              default: phase_next = PH_IDLE;
            endcase
          end
        end
        ACT_TICK: begin
          if (phase != PH_IDLE) begin
            if (elapsed_ms != 16'hFFFF) elapsed_ms_next = elapsed_ms + 16'd1;
            if (gap_ms != 16'hFFFF) gap_ms_next = gap_ms + 16'd1;
            if (gap_ms_next >= limit_ms) fin = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // End of packet: match on Command Complete or drop it
    if (eop) begin
      if (event_code_next == EVT_CMD_COMPLETE && param_length_next >= CMD_COMPLETE_MIN &&
          seen_opcode_next == wanted_opcode_next) begin
        fin         = 1'b1;
        fin_outcome = (seen_status_next == STATUS_SUCCESS) ? OUT_OK : OUT_FAILED;
        fin_status  = seen_status_next;
      end else begin
        between = 1'b1;
      end
    end

    // Between packets: check total timeout, else wait for a type byte
    if (between) begin
      event_code_next   = 8'd0;
      param_length_next = 8'd0;
      param_index_next  = 8'd0;
      seen_opcode_next  = 16'd0;
      seen_status_next  = 8'd0;
      if (elapsed_ms_next >= limit_ms_next) fin = 1'b1;
      else phase_next = PH_TYPE;
    end

    if (fin) begin
      phase_next        = PH_IDLE;
      event_code_next   = 8'd0;
      param_length_next = 8'd0;
      param_index_next  = 8'd0;
      seen_opcode_next  = 16'd0;
      seen_status_next  = 8'd0;
    end
  end

  assign res_valid       = fin;
  assign res.outcome     = fin_outcome;
  assign res.status_code = fin_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      event_code    <= 8'd0;
      param_length  <= 8'd0;
      param_index   <= 8'd0;
      seen_opcode   <= 16'd0;
      seen_status   <= 8'd0;
      wanted_opcode <= 16'd0;
      limit_ms      <= 16'd0;
      elapsed_ms    <= 16'd0;
      gap_ms        <= 16'd0;
    end else begin
      phase         <= phase_next;
      event_code    <= event_code_next;
      param_length  <= param_length_next;
      param_index   <= param_index_next;
      seen_opcode   <= seen_opcode_next;
      seen_status   <= seen_status_next;
      wanted_opcode <= wanted_opcode_next;
      limit_ms      <= limit_ms_next;
      elapsed_ms    <= elapsed_ms_next;
      gap_ms        <= gap_ms_next;
    end
  end

endmodule

// ===== rtl/hcw_out_buf.sv =====
module hcw_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  hcw_pkg::result_t data,
  output logic             room,
  hcw_out_if.source        out_ch
);
  import hcw_pkg::*;

  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;

  assign room = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ch.ready) begin
      // Output slot frees: drain skid first, else take the new item
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
        out_data  <= data;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
      skid_data  <= data;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.outcome     = out_data.outcome;
  assign out_ch.status_code = out_data.status_code;

endmodule

// ===== rtl/hci_command_complete_waiter.sv =====
// Channel  Dir  Payload                                     Handshake
// in_ch    in   action, expected_opcode, wait_ms, rx_byte   valid/ready
// out_ch   out  outcome, status_code                        valid/ready
//
// One item per cycle while ready; any result reaches out_ch from a register.
// The parser state advances in the same cycle an item is accepted.
// A two-entry output buffer (result register plus skid) lets input continue
// while one result is stalled; in_ch.ready drops only when both entries hold.
// rst is synchronous, active high: idle, not armed, all counters zero.
module hci_command_complete_waiter (
  input  logic       clk,
  input  logic       rst,
  hcw_in_if.sink     in_ch,
  hcw_out_if.source  out_ch
);
  import hcw_pkg::*;

  logic    accept;
  logic    room;
  item_t   item;
  logic    res_valid;
  result_t res;

  // Hold off input only while a result would have nowhere to go
  assign in_ch.ready = room;
  assign accept      = in_ch.valid && in_ch.ready;

  assign item.action          = in_ch.action;
  assign item.expected_opcode = in_ch.expected_opcode;
  assign item.wait_ms         = in_ch.wait_ms;
  assign item.rx_byte         = in_ch.rx_byte;

  // Frame the H4 stream, track timeouts, decide the outcome
  hcw_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  // Register the result and absorb output stalls
  hcw_out_buf u_out_buf (
    .clk    (clk),
    .rst    (rst),
    .push   (res_valid),
    .data   (res),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hcw_pkg::*;

  // Action code the block must ignore.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Cycles the result side holds off right after reset, so the output buffer fills.
  localparam int HOLD_CYCLES   = 200;
  // Cycles with no handshake on either side before the run is declared hung.
  localparam int QUIET_LIMIT   = 3000;
  // Rough number of random items to generate.
  localparam int ITEM_TARGET   = 1300;
  // Once this few items are left, both sides stop idling.
  localparam int CALM_TAIL     = 150;
  // Cycles to wait after the last awaited result, for any stray late result.
  localparam int SETTLE_CYCLES = 10;
  // Ceiling of the saturating millisecond counters.
  localparam logic [15:0] MS_CEILING = 16'hFFFF;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_TYPE,
    FR_EVENT,
    FR_LEN,
    FR_PARAMS
  } frame_phase_t;

  logic clk = 1'b0;
  logic rst;

  hcw_in_if  in_ch();
  hcw_out_if out_ch();

  hci_command_complete_waiter dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Parser mirror: frame state, armed wait and the two millisecond counters.
  // ---------------------------------------------------------------------------
  frame_phase_t frame_phase  = FR_IDLE;
  logic [7:0]   frame_code   = '0;
  logic [7:0]   frame_len    = '0;
  logic [7:0]   frame_idx    = '0;
  logic [15:0]  frame_opcode = '0;
  logic [7:0]   frame_status = '0;
  logic [15:0]  armed_opcode = '0;
  logic [15:0]  armed_limit  = '0;
  logic [15:0]  total_ms     = '0;
  logic [15:0]  idle_gap_ms  = '0;

  result_t wait_outcomes[$];   // outcomes still owed by the block, oldest first
  item_t   pending[$];         // items not yet offered to the block

  int mismatches = 0;
  int counted    = 0;          // generated items that do real work
  int taken      = 0;          // items accepted by the block

  task automatic note_mismatch(input string msg);
    mismatches++;
    $display("%0t ns mismatch: %s", $time, msg);
  endtask

  task automatic clear_frame();
    frame_code   = '0;
    frame_len    = '0;
    frame_idx    = '0;
    frame_opcode = '0;
    frame_status = '0;
  endtask

  // Owe one outcome and drop back to idle.
  task automatic conclude(input logic [1:0] outcome, input logic [7:0] status);
    result_t r;
    r.outcome     = outcome;
    r.status_code = status;
    wait_outcomes.push_back(r);
    frame_phase = FR_IDLE;
    clear_frame();
  endtask

  // Between packets the total budget is checked before the next type byte.
  task automatic between_packets();
    clear_frame();
    if (total_ms >= armed_limit) conclude(OUT_TIMEOUT, '0);
    else frame_phase = FR_TYPE;
  endtask

  task automatic close_packet();
    if (frame_code == EVT_CMD_COMPLETE && frame_len >= CMD_COMPLETE_MIN &&
        frame_opcode == armed_opcode)
      conclude(frame_status == STATUS_SUCCESS ? OUT_OK : OUT_FAILED, frame_status);
    else
      between_packets();
  endtask

  task automatic advance_parser(input item_t it);
    if (it.action == ACT_ARM) begin
      // Arming always restarts the wait, even mid-packet.
      armed_opcode = it.expected_opcode;
      armed_limit  = it.wait_ms;
      total_ms     = '0;
      idle_gap_ms  = '0;
      between_packets();
    end else if (frame_phase != FR_IDLE) begin
      case (it.action)
        ACT_BYTE: begin
          idle_gap_ms = '0;
          case (frame_phase)
            FR_TYPE: begin
              if (it.rx_byte != H4_EVENT_TYPE) between_packets();
              else frame_phase = FR_EVENT;
            end
            FR_EVENT: begin
              frame_code  = it.rx_byte;
              frame_phase = FR_LEN;
            end
            FR_LEN: begin
              frame_len = it.rx_byte;
              frame_idx = '0;
              if (frame_len == '0) close_packet();
              else frame_phase = FR_PARAMS;
            end
            FR_PARAMS: begin
              if (frame_idx == IDX_OPCODE_LO) frame_opcode[7:0] = it.rx_byte;
              else if (frame_idx == IDX_OPCODE_HI) frame_opcode[15:8] = it.rx_byte;
              else if (frame_idx == IDX_STATUS) frame_status = it.rx_byte;
              frame_idx = frame_idx + 8'd1;
              if (frame_idx >= frame_len) close_packet();
            end
            default: frame_phase = FR_IDLE;
          endcase
        end
        ACT_TICK: begin
          if (total_ms != MS_CEILING) total_ms = total_ms + 16'd1;
          if (idle_gap_ms != MS_CEILING) idle_gap_ms = idle_gap_ms + 16'd1;
          if (idle_gap_ms >= armed_limit) conclude(OUT_TIMEOUT, '0);
        end
        default: ;
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Item builders. Fields an action does not use get random values.
  // ---------------------------------------------------------------------------
  task automatic push(input logic [1:0] act, input logic [15:0] op, input logic [15:0] to,
                      input logic [7:0] b, input bit counts);
    item_t it;
    it.action          = act;
    it.expected_opcode = op;
    it.wait_ms         = to;
    it.rx_byte         = b;
    pending.push_back(it);
    if (counts) counted++;
  endtask

  task automatic arm(input logic [15:0] op, input logic [15:0] to);
    push(ACT_ARM, op, to, 8'($urandom), 1'b1);
  endtask

  task automatic tick();
    push(ACT_TICK, 16'($urandom), 16'($urandom), 8'($urandom), 1'b1);
  endtask

  // One received byte; with jitter, a tick now and then lands just before it.
  task automatic rx(input logic [7:0] b, input bit jitter);
    if (jitter && $urandom_range(0, 11) == 0) tick();
    push(ACT_BYTE, 16'($urandom), 16'($urandom), b, 1'b1);
  endtask

  task automatic send_packet(input logic [7:0] code, input logic [7:0] len,
                             input logic [15:0] op, input logic [7:0] st, input bit jitter);
    rx(H4_EVENT_TYPE, jitter);
    rx(code, jitter);
    rx(len, jitter);
    for (int i = 0; i < len; i++) begin
      if (i == IDX_OPCODE_LO) rx(op[7:0], jitter);
      else if (i == IDX_OPCODE_HI) rx(op[15:8], jitter);
      else if (i == IDX_STATUS) rx(st, jitter);
      else rx(8'($urandom), jitter);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer pending items, idle in bursts, predict on every acceptance.
  // ---------------------------------------------------------------------------
  item_t on_offer;
  int    src_gap   = 0;
  bit    tail_calm = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        advance_parser(on_offer);
        taken++;
      end
      // Tell the result side when the tail of the run has started.
      tail_calm <= (pending.size() <= CALM_TAIL);
      // Change what is offered only when nothing is stuck waiting for ready.
      if (!in_ch.valid || in_ch.ready) begin
        if (src_gap == 0 && pending.size() > CALM_TAIL && $urandom_range(0, 15) == 0)
          src_gap = $urandom_range(1, 15);
        if (src_gap > 0) begin
          src_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending.size() > 0) begin
          on_offer = pending.pop_front();
          in_ch.valid           <= 1'b1;
          in_ch.action          <= on_offer.action;
          in_ch.expected_opcode <= on_offer.expected_opcode;
          in_ch.wait_ms         <= on_offer.wait_ms;
          in_ch.rx_byte         <= on_offer.rx_byte;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each accepted result against the oldest owed outcome.
  // ---------------------------------------------------------------------------
  result_t oldest;
  int      hold_left = HOLD_CYCLES;
  int      sink_gap  = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (wait_outcomes.size() == 0) begin
          note_mismatch($sformatf("unexpected result: outcome %0d status 0x%02h",
                                  out_ch.outcome, out_ch.status_code));
        end else begin
          oldest = wait_outcomes.pop_front();
          if (out_ch.outcome !== oldest.outcome)
            note_mismatch($sformatf("outcome %0d, wanted %0d",
                                    out_ch.outcome, oldest.outcome));
          if (out_ch.status_code !== oldest.status_code)
            note_mismatch($sformatf("status_code 0x%02h, wanted 0x%02h",
                                    out_ch.status_code, oldest.status_code));
        end
      end
      if (hold_left > 0) begin
        // Hold off early on: the zero-timeout arms fill both buffer entries
        // and the block has to stall its input.
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (sink_gap == 0 && !tail_calm && $urandom_range(0, 9) == 0)
          sink_gap = $urandom_range(1, 15);
        if (sink_gap > 0) begin
          sink_gap--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: end the run if neither side moves an item for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    int          total;
    int          n;
    logic [15:0] op;
    logic [15:0] to;
    logic [7:0]  b;

    rst = 1'b1;

    // Zero timeout answers at once; three in a row overrun the output buffer
    // while the result side is held off.
    repeat (3) arm(16'($urandom), 16'h0000);

    // Skip a non-event type byte, then a minimal matching Command Complete.
    arm(16'h0C03, 16'hFFFF);
    rx(8'h01, 1'b0);
    send_packet(EVT_CMD_COMPLETE, CMD_COMPLETE_MIN, 16'h0C03, STATUS_SUCCESS, 1'b0);

    // Discard a zero-length event, a too-short one and a foreign event code;
    // then match with the all-ones status.
    arm(16'hFFFF, 16'hFFFF);
    send_packet(EVT_CMD_COMPLETE, 8'd0, 16'hFFFF, STATUS_SUCCESS, 1'b0);
    send_packet(EVT_CMD_COMPLETE, 8'd3, 16'hFFFF, STATUS_SUCCESS, 1'b0);
    send_packet(8'h3E, CMD_COMPLETE_MIN, 16'hFFFF, STATUS_SUCCESS, 1'b0);
    send_packet(EVT_CMD_COMPLETE, CMD_COMPLETE_MIN, 16'hFFFF, 8'hFF, 1'b0);

    // Byte-gap timeout on the first tick.
    arm(16'h0000, 16'd1);
    tick();

    // Total timeout: bytes keep the gap short, the noise byte finds time up.
    arm(16'h0000, 16'd2);
    tick();
    rx(8'hFF, 1'b0);
    tick();
    rx(8'h00, 1'b0);

    // Not armed: ticks, bytes and the unused action do nothing.
    push(ACT_TICK, 16'($urandom), 16'($urandom), 8'($urandom), 1'b0);
    push(ACT_BYTE, 16'($urandom), 16'($urandom), H4_EVENT_TYPE, 1'b0);
    push(ACT_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0);

    // Re-arm mid-packet drops the partial packet.
    arm(16'h0C03, 16'hFFFF);
    rx(H4_EVENT_TYPE, 1'b0);
    rx(EVT_CMD_COMPLETE, 1'b0);
    arm(16'h0C03, 16'hFFFF);
    send_packet(EVT_CMD_COMPLETE, 8'd6, 16'h0C03, 8'h01, 1'b0);

    // Random waits: mostly well-formed traffic around one armed opcode, with
    // noise, foreign events, short events, restarts and ticks mixed in.
    counted = 0;
    while (counted < ITEM_TARGET) begin
      case ($urandom_range(0, 5))
        0:       op = 16'h0000;
        1:       op = 16'hFFFF;
        2:       op = 16'h0C03;
        default: op = 16'($urandom);
      endcase
      case ($urandom_range(0, 7))
        0:       to = 16'h0000;
        1:       to = 16'hFFFF;
        2, 3:    to = 16'($urandom);
        default: to = 16'($urandom_range(1, 12));
      endcase
      arm(op, to);

      repeat ($urandom_range(0, 4)) begin
        case ($urandom_range(0, 6))
          0: begin
            do b = 8'($urandom); while (b == H4_EVENT_TYPE);
            rx(b, 1'b1);
          end
          1: begin
            do b = 8'($urandom); while (b == EVT_CMD_COMPLETE);
            send_packet(b, 8'($urandom_range(0, 8)), op, 8'($urandom), 1'b1);
          end
          2: send_packet(EVT_CMD_COMPLETE, 8'($urandom_range(0, 3)), op, 8'($urandom), 1'b1);
          3: repeat ($urandom_range(1, 3)) tick();
          4: send_packet(EVT_CMD_COMPLETE, 8'($urandom_range(4, 9)),
                         op ^ (16'd1 << $urandom_range(0, 15)), 8'($urandom), 1'b1);
          5: begin
            // Abandon a packet part way and arm again.
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++) begin
              if (k == 0) rx(H4_EVENT_TYPE, 1'b1);
              else if (k == 1) rx(EVT_CMD_COMPLETE, 1'b1);
              else if (k == 2) rx(8'($urandom_range(4, 8)), 1'b1);
              else rx(8'($urandom), 1'b1);
            end
            arm(op, to);
          end
          default: rx(8'($urandom), 1'b1);
        endcase
      end

      case ($urandom_range(0, 9))
        7, 8: if (to <= 16'd40) repeat (to) tick();
        9:    ;
        default: begin
          b = ($urandom_range(0, 1) == 0) ? STATUS_SUCCESS : 8'($urandom_range(1, 255));
          send_packet(EVT_CMD_COMPLETE, 8'($urandom_range(4, 10)), op, b, 1'b1);
        end
      endcase

      // Now and then some traffic that is ignored when nothing is armed.
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 2))
            0:       push(ACT_UNUSED, 16'($urandom), 16'($urandom), 8'($urandom), 1'b0);
            1:       push(ACT_TICK, 16'($urandom), 16'($urandom), 8'($urandom), 1'b0);
            default: push(ACT_BYTE, 16'($urandom), 16'($urandom), 8'($urandom), 1'b0);
          endcase
        end
      end
    end
    total = pending.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Drain: every item accepted, every owed outcome seen, then a short settle.
    while (taken < total) @(posedge clk);
    while (wait_outcomes.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== hci_command_complete_waiter.f =====
rtl/hcw_pkg.sv
rtl/hcw_if.sv
rtl/hcw_core.sv
rtl/hcw_out_buf.sv
rtl/hci_command_complete_waiter.sv
bench/tb_top.sv
